// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate consequence: when cond holds, expr holds on the same edge.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Next-cycle consequence: when cond holds, expr holds on the following edge.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

// ----- hdl/pssg_pkg.sv -----
package pssg_pkg;

   localparam int NumDomainsDefault = 4;
   localparam int ThrW              = 24;
   localparam int NumThr            = 3;
   localparam int CsrIdxW           = 2;

   localparam logic [2:0] LEVEL_RESTORE = 3'd4;

   typedef enum logic [1:0] {
      MODE_CHECK  = 2'd0,
      MODE_NOTICE = 2'd1,
      MODE_TICK   = 2'd2
   } mode_type;

   typedef enum logic [CsrIdxW-1:0] {
      REG_IDLE_THR    = 2'd0,
      REG_STANDBY_THR = 2'd1,
      REG_SLEEP_THR   = 2'd2
   } reg_index_type;

   typedef logic [ThrW-1:0] thr_type;
   typedef thr_type [NumThr-1:0] thr_array_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] domain;
      logic [3:0] lock_mask;
      logic [2:0] new_state;
      logic [1:0] current_state;
   } item_type;

   typedef struct packed {
      logic [1:0] chosen_state;
      logic       held_back;
      logic       timer_running;
   } result_type;

   function automatic thr_type level_threshold(thr_array_type thr, logic [1:0] level);
      thr_type t;
      t = '0;
      if (level != 2'd0) begin
         t = thr[2'(level - 2'd1)];
      end
      return t;
   endfunction

   function automatic logic [1:0] first_locked(logic [3:0] mask);
      logic [1:0] lv;
      priority if (mask[0]) begin
         lv = 2'd0;
      end else if (mask[1]) begin
         lv = 2'd1;
      end else if (mask[2]) begin
         lv = 2'd2;
      end else begin
         lv = 2'd3;
      end
      return lv;
   endfunction

   // Highest level at or below present whose threshold is zero.
   function automatic logic [1:0] hold_level(thr_array_type thr, logic [1:0] present);
      logic [1:0] lv;
      lv = 2'd0;
      priority if (present >= 2'd3 && thr[2] == '0) begin
         lv = 2'd3;
      end else if (present >= 2'd2 && thr[1] == '0) begin
         lv = 2'd2;
      end else if (present >= 2'd1 && thr[0] == '0) begin
         lv = 2'd1;
      end else begin
         lv = 2'd0;
      end
      return lv;
   endfunction

endpackage

// ----- hdl/pssg_engine.sv -----
module pssg_engine #(
   parameter int NUM_DOMAINS = pssg_pkg::NumDomainsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_en,
   input  pssg_pkg::item_type      item,
   input  pssg_pkg::thr_array_type thr,
   output pssg_pkg::result_type    result
);

   localparam int DomW = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;

   logic [1:0]            pending_ff [NUM_DOMAINS];
   logic                  woke_ff    [NUM_DOMAINS];
   pssg_pkg::thr_type     left_ff    [NUM_DOMAINS];
   logic                  armed_ff   [NUM_DOMAINS];

   logic [1:0]            pending_in;
   logic                  woke_in;
   pssg_pkg::thr_type     left_in;
   logic                  armed_in;

   logic [DomW-1:0]       idx;
   logic                  in_range;
   logic [1:0]            cand;
   logic [1:0]            pend;
   pssg_pkg::thr_type     cand_thr;
   pssg_pkg::thr_type     pend_thr;
   pssg_pkg::thr_type     left_dec;

   assign idx      = DomW'(item.domain);
   assign in_range = 32'(item.domain) < 32'(NUM_DOMAINS);
   assign cand     = pssg_pkg::first_locked(item.lock_mask);
   assign pend     = pending_ff[idx];
   assign cand_thr = pssg_pkg::level_threshold(thr, cand);
   assign pend_thr = pssg_pkg::level_threshold(thr, pend);
   assign left_dec = (left_ff[idx] != '0) ? left_ff[idx] - 1'b1 : '0;

   always_comb begin
      pending_in = pend;
      woke_in    = woke_ff[idx];
      left_in    = left_ff[idx];
      armed_in   = armed_ff[idx];
      result     = '0;
      unique case (item.mode)
         pssg_pkg::MODE_CHECK: begin
            pending_in          = cand;
            woke_in             = 1'b0;
            result.chosen_state = cand;
            if (cand_thr != '0 && (!woke_ff[idx] || pend != cand)) begin
               result.chosen_state = pssg_pkg::hold_level(thr, item.current_state);
               result.held_back    = 1'b1;
            end
         end
         pssg_pkg::MODE_NOTICE: begin
            if (item.new_state == pssg_pkg::LEVEL_RESTORE) begin
               if (armed_ff[idx]) begin
                  if (left_ff[idx] == '0) begin
                     woke_in = 1'b1;
                  end
                  armed_in = 1'b0;
                  left_in  = '0;
               end
            end else if (item.new_state < pssg_pkg::LEVEL_RESTORE) begin
               if (pend_thr != '0 && {1'b0, pend} != item.new_state) begin
                  armed_in = 1'b1;
                  left_in  = pend_thr;
               end
            end
         end
         pssg_pkg::MODE_TICK: begin
            if (armed_ff[idx]) begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  armed_in = 1'b0;
                  woke_in  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      result.timer_running = armed_in;
      if (!in_range) begin
         result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DOMAINS; i++) begin
            pending_ff[i] <= '0;
            woke_ff[i]    <= 1'b0;
            left_ff[i]    <= '0;
            armed_ff[i]   <= 1'b0;
         end
      end else if (item_en && in_range) begin
         pending_ff[idx] <= pending_in;
         woke_ff[idx]    <= woke_in;
         left_ff[idx]    <= left_in;
         armed_ff[idx]   <= armed_in;
      end
   end

endmodule

// ----- hdl/power_state_stability_governor.sv -----
// channel  dir  beat fields (low bit first)
// req      in   tuser: mode; tdata: domain, lock_mask, new_state, current_state
// rsp      out  tdata: chosen_state, held_back, timer_running
// csr      in   csr_index: register, csr_data: threshold value
//
// One beat per cycle sustained while rsp is not stalled; the req beat lands in the input register,
// and the result register, which drives rsp valid, loads from it once rsp can advance.
// A stalled rsp still lets one more req beat into the input register.
// Synchronous reset clears all domain state, thresholds and valid flags.
// csr is always ready; writes take effect on the next item.
module power_state_stability_governor #(
   parameter int NUM_DOMAINS = pssg_pkg::NumDomainsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [15:0]                  req_tdata,  // domain, lock_mask, new_state, current_state
   input  logic [1:0]                   req_tuser,  // mode
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,  // chosen_state, held_back, timer_running
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pssg_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pssg_pkg::ThrW-1:0]    csr_data
);

   pssg_pkg::item_type      item_ff;
   logic                    item_valid_ff;
   pssg_pkg::result_type    rsp_ff;
   logic                    rsp_valid_ff;
   pssg_pkg::thr_array_type thr_ff;
   pssg_pkg::result_type    result;
   pssg_pkg::item_type      item_in;
   logic                    advance;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !item_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign item_in.mode          = req_tuser;
   assign item_in.domain        = req_tdata[1:0];
   assign item_in.lock_mask     = req_tdata[5:2];
   assign item_in.new_state     = req_tdata[8:6];
   assign item_in.current_state = req_tdata[10:9];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pssg_pkg::REG_IDLE_THR:    thr_ff[0] <= csr_data;
            pssg_pkg::REG_STANDBY_THR: thr_ff[1] <= csr_data;
            pssg_pkg::REG_SLEEP_THR:   thr_ff[2] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   pssg_engine #(
      .NUM_DOMAINS(NUM_DOMAINS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .item_en (item_valid_ff && advance),
      .item    (item_ff),
      .thr     (thr_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_valid_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.timer_running, rsp_ff.held_back, rsp_ff.chosen_state};

endmodule

// ----- hdl/pssg_checker.sv -----
`include "assert_macros.svh"

module pssg_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [7:0]                   rsp_tdata,
   input logic                         csr_valid,
   input logic                         csr_ready
);

   logic req_beat;
   logic rsp_stall;

   assign req_beat  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPLIES(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[7:4] == 4'b0)
   `ASSERT_NEXT(a_rsp_latency, clock, reset, req_beat && rsp_tready ##1 rsp_tready, rsp_tvalid)
   `ASSERT_IMPLIES(a_req_open, clock, reset, !rsp_tvalid, req_tready)
   `ASSERT_IMPLIES(a_csr_open, clock, reset, csr_valid, csr_ready)

endmodule

bind power_state_stability_governor pssg_checker u_pssg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
